FILE: design/ttcm_pkg.sv
// ----------------------------------------------------------------------------
// ttcm_pkg: shared types and constants of the threshold trigger monitor
// Item layouts, command and operation codes, mode codes, register map.
// ----------------------------------------------------------------------------
package ttcm_pkg;

  localparam int WINDOW_DEPTH_DEF = 32;

  localparam int CMD_W  = 4;
  localparam int SAD_W  = 24;
  localparam int CNT_W  = 32;
  localparam int MODE_W = 2;
  localparam int THR_W  = 24;
  localparam int CD_W   = 16;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_ARMED_SAMPLE  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT_SAMPLE = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ENABLE        = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DISABLE       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_ARM           = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DISARM        = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PASS          = 4'd6;
  localparam logic [CMD_W-1:0] CMD_TICK          = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR         = 4'd8;

  localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENABLED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARMED    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COOLDOWN = 2'd3;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_AUTO_FIRE = 2'd1;
  localparam logic [1:0] REG_COOLDOWN  = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 24'd1000;
  localparam logic             AUTO_FIRE_RESET = 1'b1;
  localparam logic [CD_W-1:0]  COOLDOWN_RESET  = 16'd1000;

  typedef enum logic [3:0] {
    OP_ARMED_SAMPLE,
    OP_REPORT_SAMPLE,
    OP_ENABLE,
    OP_DISABLE,
    OP_ARM,
    OP_DISARM,
    OP_PASS,
    OP_TICK,
    OP_CLEAR,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SAD_W-1:0] sad_value;
  } cmd_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode_now;
    logic              fire_servo;
    logic              detected;
    logic              rearmed;
    logic              mode_changed;
    logic [CNT_W-1:0]  detection_total;
    logic [CNT_W-1:0]  fire_total;
    logic [SAD_W-1:0]  sample_min;
    logic [SAD_W-1:0]  sample_max;
    logic [SAD_W-1:0]  sample_average;
  } res_item_t;

  typedef struct packed {
    op_t              op;
    logic             is_sample;
    logic [SAD_W-1:0] sad_value;
  } q_entry_t;

  typedef struct packed {
    logic [THR_W-1:0] detect_threshold;
    logic             auto_fire;
    logic [CD_W-1:0]  cooldown_ticks;
  } cfg_t;

endpackage

FILE: design/ttcm_ram.sv
// ----------------------------------------------------------------------------
// ttcm_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ttcm_front.sv
// ----------------------------------------------------------------------------
// ttcm_front: command intake
// Accept items, decode the command into an operation, hold them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ttcm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  ttcm_pkg::cmd_item_t cmd_item,
  output logic                q_valid,
  output ttcm_pkg::q_entry_t  q_head,
  input  logic                q_pop
);
  import ttcm_pkg::*;

  q_entry_t   fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  q_entry_t   entry;

  always_comb begin
    entry.sad_value = cmd_item.sad_value;
    entry.is_sample = 1'b0;
    case (cmd_item.command)
      CMD_ARMED_SAMPLE: begin
        entry.op        = OP_ARMED_SAMPLE;
        entry.is_sample = 1'b1;
      end
      CMD_REPORT_SAMPLE: begin
        entry.op        = OP_REPORT_SAMPLE;
        entry.is_sample = 1'b1;
      end
      CMD_ENABLE:  entry.op = OP_ENABLE;
      CMD_DISABLE: entry.op = OP_DISABLE;
      CMD_ARM:     entry.op = OP_ARM;
      CMD_DISARM:  entry.op = OP_DISARM;
      CMD_PASS:    entry.op = OP_PASS;
      CMD_TICK:    entry.op = OP_TICK;
      CMD_CLEAR:   entry.op = OP_CLEAR;
      default:     entry.op = OP_IGNORE;
    endcase
  end

  assign cmd_stall = (count == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign q_valid   = (count != 2'd0);
  assign q_head    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/ttcm_back.sv
// ----------------------------------------------------------------------------
// ttcm_back: command execution
// Mode and cooldown control, saturating counters, min/max marks, sliding
// window in RAM and a bit-serial divider for the window average.
// ----------------------------------------------------------------------------
module ttcm_back #(
  parameter int WINDOW_DEPTH = ttcm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ttcm_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  ttcm_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_stall,
  output ttcm_pkg::res_item_t res_item
);
  import ttcm_pkg::*;

  localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAD_W + $clog2(WINDOW_DEPTH);
  localparam int DCNT_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } back_state_t;

  back_state_t       state;
  q_entry_t          cur;
  logic [MODE_W-1:0] mode;
  logic [CD_W-1:0]   cooldown_left;
  logic [SUM_W-1:0]  window_sum;
  logic [FILL_W-1:0] window_fill;
  logic [POS_W-1:0]  window_pos;
  logic [SAD_W-1:0]  low_mark;
  logic [SAD_W-1:0]  high_mark;
  logic [CNT_W-1:0]  detections;
  logic [CNT_W-1:0]  firings;
  logic [SAD_W-1:0]  average;
  logic [SAD_W-1:0]  old_sample;
  res_item_t         res;

  logic [SUM_W-1:0]  dq;
  logic [FILL_W-1:0] rem;
  logic [DCNT_W-1:0] dcnt;
  logic [FILL_W:0]   trial;
  logic              ge;
  logic [SUM_W-1:0]  dq_next;

  logic [MODE_W-1:0] mode_next;
  logic [CD_W-1:0]   cooldown_left_next;
  logic [SUM_W-1:0]  window_sum_next;
  logic [FILL_W-1:0] window_fill_next;
  logic [POS_W-1:0]  window_pos_next;
  logic [SAD_W-1:0]  low_mark_next;
  logic [SAD_W-1:0]  high_mark_next;
  logic [CNT_W-1:0]  detections_next;
  logic [CNT_W-1:0]  firings_next;
  logic              fire;
  logic              det;
  logic              rearm;
  logic              changed;
  logic              full;
  logic              out_free;
  logic              ram_we;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !res_valid || !res_stall;
  assign full     = (window_fill == FILL_W'(WINDOW_DEPTH));
  assign ram_we   = (state == S_EXEC) && cur.is_sample;

  ttcm_ram #(
    .WIDTH (SAD_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (window_pos),
    .wdata (cur.sad_value),
    .raddr (window_pos),
    .rdata (old_sample)
  );

  always_comb begin
    mode_next          = mode;
    cooldown_left_next = cooldown_left;
    window_sum_next    = window_sum;
    window_fill_next   = window_fill;
    window_pos_next    = window_pos;
    low_mark_next      = low_mark;
    high_mark_next     = high_mark;
    detections_next    = detections;
    firings_next       = firings;
    fire               = 1'b0;
    det                = 1'b0;
    rearm              = 1'b0;
    changed            = 1'b0;

    if (cur.is_sample) begin
      window_sum_next = window_sum + SUM_W'(cur.sad_value)
                        - (full ? SUM_W'(old_sample) : SUM_W'(0));
      window_fill_next = full ? window_fill : window_fill + FILL_W'(1);
      window_pos_next  = (window_pos == POS_W'(WINDOW_DEPTH - 1)) ? POS_W'(0)
                         : window_pos + POS_W'(1);
      if (cur.sad_value > high_mark) begin
        high_mark_next = cur.sad_value;
      end
      if (cur.sad_value < low_mark) begin
        low_mark_next = cur.sad_value;
      end
    end

    case (cur.op)
      OP_ARMED_SAMPLE: begin
        if (mode == MODE_COOLDOWN && cooldown_left == '0) begin
          mode_next = MODE_ARMED;
          rearm     = 1'b1;
        end
        if (mode_next == MODE_ARMED && cur.sad_value > cfg.detect_threshold) begin
          det             = 1'b1;
          detections_next = (detections == '1) ? detections : detections + CNT_W'(1);
          if (cfg.auto_fire) begin
            fire         = 1'b1;
            firings_next = (firings == '1) ? firings : firings + CNT_W'(1);
          end
          cooldown_left_next = cfg.cooldown_ticks;
          mode_next          = MODE_COOLDOWN;
        end
      end
      OP_REPORT_SAMPLE: begin
        if (mode == MODE_ENABLED && cur.sad_value > cfg.detect_threshold) begin
          det             = 1'b1;
          detections_next = (detections == '1) ? detections : detections + CNT_W'(1);
        end
      end
      OP_ENABLE: begin
        if (mode == MODE_DISABLED) begin
          mode_next = MODE_ENABLED;
          changed   = 1'b1;
        end
      end
      OP_DISABLE: begin
        mode_next = MODE_DISABLED;
        changed   = (mode != MODE_DISABLED);
      end
      OP_ARM: begin
        if (mode == MODE_ENABLED) begin
          mode_next = MODE_ARMED;
          changed   = 1'b1;
        end
      end
      OP_DISARM: begin
        if (mode == MODE_ARMED) begin
          mode_next = MODE_ENABLED;
          changed   = 1'b1;
        end
      end
      OP_PASS: begin
        if (mode == MODE_COOLDOWN && cooldown_left == '0) begin
          mode_next = MODE_ARMED;
          rearm     = 1'b1;
        end
      end
      OP_TICK: begin
        if (cooldown_left != '0) begin
          cooldown_left_next = cooldown_left - CD_W'(1);
        end
      end
      OP_CLEAR: begin
        window_sum_next  = '0;
        window_fill_next = '0;
        window_pos_next  = '0;
        low_mark_next    = '1;
        high_mark_next   = '0;
        detections_next  = '0;
        firings_next     = '0;
      end
      default: begin
      end
    endcase
  end

  assign trial   = {rem, dq[SUM_W-1]};
  assign ge      = (trial >= {1'b0, window_fill});
  assign dq_next = {dq[SUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur <= q_head;
        end
      end
      S_EXEC: begin
        res.mode_now        <= mode_next;
        res.fire_servo      <= fire;
        res.detected        <= det;
        res.rearmed         <= rearm;
        res.mode_changed    <= changed;
        res.detection_total <= detections_next;
        res.fire_total      <= firings_next;
        res.sample_min      <= low_mark_next;
        res.sample_max      <= high_mark_next;
        res.sample_average  <= (cur.op == OP_CLEAR) ? '0 : average;
        dq                  <= window_sum_next;
        rem                 <= '0;
        dcnt                <= DCNT_W'(SUM_W - 1);
      end
      S_DIV: begin
        dq   <= dq_next;
        rem  <= ge ? FILL_W'(trial - {1'b0, window_fill}) : FILL_W'(trial);
        dcnt <= dcnt - DCNT_W'(1);
        if (dcnt == '0) begin
          res.sample_average <= dq_next[SAD_W-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          res_item <= res;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= MODE_DISABLED;
      cooldown_left <= '0;
      window_sum    <= '0;
      window_fill   <= '0;
      window_pos    <= '0;
      low_mark      <= '1;
      high_mark     <= '0;
      detections    <= '0;
      firings       <= '0;
      average       <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_head.is_sample ? S_READ : S_EXEC;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          mode          <= mode_next;
          cooldown_left <= cooldown_left_next;
          window_sum    <= window_sum_next;
          window_fill   <= window_fill_next;
          window_pos    <= window_pos_next;
          low_mark      <= low_mark_next;
          high_mark     <= high_mark_next;
          detections    <= detections_next;
          firings       <= firings_next;
          if (cur.op == OP_CLEAR) begin
            average <= '0;
          end
          state <= cur.is_sample ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (dcnt == '0) begin
            average <= dq_next[SAD_W-1:0];
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/threshold_trigger_cooldown_monitor_core.sv
// ----------------------------------------------------------------------------
// threshold_trigger_cooldown_monitor_core: threshold trigger monitor
// Mode control with cooldown, detection and firing counts, sample min/max
// and sliding-window average, with an APB register port.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  cmd       cmd_valid / cmd_stall / cmd_item  in   (command, sad_value)
//  res       res_valid / res_stall / res_item  out  (one result per command)
//  apb       psel penable pwrite paddr ...     in   (register access)
//
// Non-sample commands pass through the idle, execute and output states; sample
// commands also read the window RAM first and run the bit-serial divider.
// A two-entry queue lets intake continue while the back end works or the
// result waits under stall. Reset is synchronous; the window RAM needs no
// clearing pass, its fill count marks the valid entries.
// ----------------------------------------------------------------------------
module threshold_trigger_cooldown_monitor_core #(
  parameter int WINDOW_DEPTH = ttcm_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  ttcm_pkg::cmd_item_t                 cmd_item,
  output logic                                res_valid,
  input  logic                                res_stall,
  output ttcm_pkg::res_item_t                 res_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ttcm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ttcm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ttcm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import ttcm_pkg::*;

  cfg_t       cfg;
  logic       q_valid;
  logic       q_pop;
  q_entry_t   q_head;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_threshold <= THRESHOLD_RESET;
      cfg.auto_fire        <= AUTO_FIRE_RESET;
      cfg.cooldown_ticks   <= COOLDOWN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: begin
          if (pwdata[THR_W-1:0] != '0) begin
            cfg.detect_threshold <= pwdata[THR_W-1:0];
          end
        end
        REG_AUTO_FIRE: cfg.auto_fire <= pwdata[0];
        REG_COOLDOWN: begin
          if (pwdata[CD_W-1:0] != '0) begin
            cfg.cooldown_ticks <= pwdata[CD_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DATA_W'(cfg.detect_threshold);
      REG_AUTO_FIRE: prdata = APB_DATA_W'(cfg.auto_fire);
      REG_COOLDOWN:  prdata = APB_DATA_W'(cfg.cooldown_ticks);
      default:       prdata = '0;
    endcase
  end

  ttcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  ttcm_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

FILE: design/ttcm_checker.sv
// ----------------------------------------------------------------------------
// ttcm_port_checker: port-level assertions for the trigger monitor
// Watches the result channel for handshake and flag consistency.
// ----------------------------------------------------------------------------
module ttcm_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_stall,
  input ttcm_pkg::res_item_t res_item
);
  import ttcm_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result item changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_fire_detect: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.fire_servo |->
      res_item.detected && res_item.mode_now == MODE_COOLDOWN)
    else $error("fire without detection entering cooldown");

  a_rearm_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.rearmed |->
      !res_item.mode_changed &&
      (res_item.mode_now == MODE_ARMED || res_item.mode_now == MODE_COOLDOWN))
    else $error("rearm flag with wrong mode");

endmodule

bind threshold_trigger_cooldown_monitor_core ttcm_port_checker u_checker (.*);

FILE: verif/ttcm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttcm_checker: result checker for the threshold trigger monitor
// Watches the command, result and register channels. Keeps its own copy of
// the registers, the mode, the cooldown count and the sample statistics,
// works out the status due for every accepted command and compares each
// accepted result with the oldest one due, field by field.
// ----------------------------------------------------------------------------
module ttcm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  logic                            cmd_stall,
  input  ttcm_pkg::cmd_item_t             cmd_item,
  input  logic                            res_valid,
  input  logic                            res_stall,
  input  ttcm_pkg::res_item_t             res_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ttcm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ttcm_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              pending
);
  import ttcm_pkg::*;

  logic [THR_W-1:0]  thr;
  logic              af;
  logic [CD_W-1:0]   cd_ticks;
  logic [MODE_W-1:0] mode;
  logic [CD_W-1:0]   cd_left;
  logic [SAD_W-1:0]  win [WINDOW_DEPTH_DEF];
  logic [63:0]       win_sum;
  int                win_fill;
  int                win_pos;
  logic [SAD_W-1:0]  lo_mark;
  logic [SAD_W-1:0]  hi_mark;
  logic [CNT_W-1:0]  n_det;
  logic [CNT_W-1:0]  n_fire;
  res_item_t         status_due [$];
  int                errors = 0;
  int                n_results = 0;

  function logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] v);
    return (&v) ? v : v + CNT_W'(1);
  endfunction

  function void clear_stats();
    win_sum  = '0;
    win_fill = 0;
    win_pos  = 0;
    lo_mark  = '1;
    hi_mark  = '0;
    n_det    = '0;
    n_fire   = '0;
  endfunction

  function void add_sample(logic [SAD_W-1:0] v);
    if (win_fill >= WINDOW_DEPTH_DEF) begin
      win_sum = win_sum - 64'(win[win_pos]);
    end else begin
      win_fill++;
    end
    win[win_pos] = v;
    win_sum = win_sum + 64'(v);
    win_pos = (win_pos == WINDOW_DEPTH_DEF - 1) ? 0 : win_pos + 1;
    if (v > hi_mark) hi_mark = v;
    if (v < lo_mark) lo_mark = v;
  endfunction

  function logic leave_cooldown();
    if (mode == MODE_COOLDOWN && cd_left == '0) begin
      mode = MODE_ARMED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function res_item_t next_status(cmd_item_t it);
    res_item_t         r;
    logic [MODE_W-1:0] prior;
    logic [63:0]       avg;
    r     = '0;
    prior = mode;
    case (it.command)
      CMD_ARMED_SAMPLE: begin
        add_sample(it.sad_value);
        r.rearmed = leave_cooldown();
        if (mode == MODE_ARMED && it.sad_value > thr) begin
          r.detected = 1'b1;
          n_det = sat_up(n_det);
          if (af) begin
            r.fire_servo = 1'b1;
            n_fire = sat_up(n_fire);
          end
          cd_left = cd_ticks;
          mode    = MODE_COOLDOWN;
        end
      end
      CMD_REPORT_SAMPLE: begin
        add_sample(it.sad_value);
        if (mode == MODE_ENABLED && it.sad_value > thr) begin
          r.detected = 1'b1;
          n_det = sat_up(n_det);
        end
      end
      CMD_ENABLE: begin
        if (mode == MODE_DISABLED) mode = MODE_ENABLED;
        r.mode_changed = (mode != prior);
      end
      CMD_DISABLE: begin
        mode = MODE_DISABLED;
        r.mode_changed = (mode != prior);
      end
      CMD_ARM: begin
        if (mode == MODE_ENABLED) mode = MODE_ARMED;
        r.mode_changed = (mode != prior);
      end
      CMD_DISARM: begin
        if (mode == MODE_ARMED) mode = MODE_ENABLED;
        r.mode_changed = (mode != prior);
      end
      CMD_PASS: begin
        r.rearmed = leave_cooldown();
      end
      CMD_TICK: begin
        if (cd_left != '0) cd_left = cd_left - CD_W'(1);
      end
      CMD_CLEAR: begin
        clear_stats();
      end
      default: ;
    endcase
    avg = (win_fill != 0) ? win_sum / 64'(win_fill) : 64'd0;
    r.mode_now        = mode;
    r.detection_total = n_det;
    r.fire_total      = n_fire;
    r.sample_min      = lo_mark;
    r.sample_max      = hi_mark;
    r.sample_average  = avg[SAD_W-1:0];
    return r;
  endfunction

  task check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d, %s: expected %h, got %h", n_results, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      thr      = THRESHOLD_RESET;
      af       = AUTO_FIRE_RESET;
      cd_ticks = COOLDOWN_RESET;
      mode     = MODE_DISABLED;
      cd_left  = '0;
      clear_stats();
      status_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (paddr[3:2])
          REG_THRESHOLD: if (pwdata[THR_W-1:0] != '0) thr = pwdata[THR_W-1:0];
          REG_AUTO_FIRE: af = pwdata[0];
          REG_COOLDOWN:  if (pwdata[CD_W-1:0] != '0) cd_ticks = pwdata[CD_W-1:0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with no item pending", n_results);
        end else begin
          want = status_due[0];
          status_due.delete(0);
          check_field("mode_now", 32'(want.mode_now), 32'(res_item.mode_now));
          check_field("fire_servo", 32'(want.fire_servo), 32'(res_item.fire_servo));
          check_field("detected", 32'(want.detected), 32'(res_item.detected));
          check_field("rearmed", 32'(want.rearmed), 32'(res_item.rearmed));
          check_field("mode_changed", 32'(want.mode_changed),
                      32'(res_item.mode_changed));
          check_field("detection_total", want.detection_total, res_item.detection_total);
          check_field("fire_total", want.fire_total, res_item.fire_total);
          check_field("sample_min", 32'(want.sample_min), 32'(res_item.sample_min));
          check_field("sample_max", 32'(want.sample_max), 32'(res_item.sample_max));
          check_field("sample_average", 32'(want.sample_average),
                      32'(res_item.sample_average));
        end
        n_results++;
      end
      if (cmd_valid && !cmd_stall) begin
        status_due.insert(status_due.size(), next_status(cmd_item));
      end
    end
    pending    <= status_due.size();
    fail_count <= errors;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the threshold trigger monitor
// Drives a directed command sequence through every mode transition and
// corner of the statistics, then random command streams under several
// register settings with random idling, a long result hold-off and a run
// with no idling. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ttcm_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cmd_valid = 1'b0;
  cmd_item_t             cmd_item  = '0;
  logic                  res_stall = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic                  cmd_stall;
  logic                  res_valid;
  res_item_t             res_item;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  bit                    gaps_on   = 1'b1;
  bit                    stalls_on = 1'b1;
  int                    hold_left = 0;
  logic [THR_W-1:0]      thr_now   = THRESHOLD_RESET;

  threshold_trigger_cooldown_monitor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  ttcm_checker CHECK (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= stalls_on && ($urandom_range(99) < 6);
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, logic [SAD_W-1:0] sad);
    if (gaps_on && $urandom_range(99) < 6) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_valid          <= 1'b1;
    cmd_item.command   <= cmd;
    cmd_item.sad_value <= sad;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_THRESHOLD && value[THR_W-1:0] != '0) thr_now = value[THR_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic [SAD_W-1:0] pick_sad();
    case ($urandom_range(4))
      0:       return SAD_W'(thr_now - 2 + $urandom_range(4));
      1:       return SAD_W'($urandom);
      2:       return SAD_W'($urandom_range(2047));
      3:       return $urandom_range(1) ? '1 : '0;
      default: return SAD_W'(thr_now + $urandom_range(1, 100000));
    endcase
  endfunction

  task automatic rand_item();
    logic [CMD_W-1:0] cmd;
    int               p;
    p = $urandom_range(99);
    if (p < 30)      cmd = CMD_ARMED_SAMPLE;
    else if (p < 40) cmd = CMD_REPORT_SAMPLE;
    else if (p < 62) cmd = CMD_TICK;
    else if (p < 70) cmd = CMD_PASS;
    else if (p < 77) cmd = CMD_ENABLE;
    else if (p < 86) cmd = CMD_ARM;
    else if (p < 89) cmd = CMD_DISARM;
    else if (p < 93) cmd = CMD_DISABLE;
    else if (p < 94) cmd = CMD_CLEAR;
    else if (p < 96) cmd = CMD_W'($urandom_range(9, 15));
    else             cmd = CMD_ARMED_SAMPLE;
    send(cmd, pick_sad());
  endtask

  task automatic run_phase(int n, logic [THR_W-1:0] thr, logic af, logic [CD_W-1:0] cd,
                           bit with_hold);
    wait_idle();
    write_reg(REG_THRESHOLD, {8'($urandom), thr});
    write_reg(REG_AUTO_FIRE, {($urandom_range(1) ? 31'h7FFF_FFFF : 31'h0), af});
    write_reg(REG_COOLDOWN, {16'($urandom), cd});
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == 60) hold_left = 300;
      rand_item();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send(CMD_TICK, '0);
    send(CMD_PASS, '0);
    send(CMD_REPORT_SAMPLE, '0);
    send(CMD_REPORT_SAMPLE, '1);
    send(4'd9, '1);
    send(4'd15, 24'h5A5A5A);
    send(CMD_ENABLE, '0);
    send(CMD_ENABLE, '0);
    send(CMD_REPORT_SAMPLE, 24'd1001);
    send(CMD_ARM, '0);
    send(CMD_ARM, '0);
    send(CMD_DISARM, '0);
    send(CMD_DISARM, '0);
    send(CMD_ARM, '0);
    send(CMD_ARMED_SAMPLE, 24'd1000);
    send(CMD_ARMED_SAMPLE, 24'd1001);
    send(CMD_ARMED_SAMPLE, '1);
    send(CMD_PASS, '0);
    send(CMD_DISARM, '0);
    send(CMD_TICK, '0);
    send(CMD_CLEAR, '0);
    send(CMD_DISABLE, '0);
    send(CMD_DISABLE, '0);

    wait_idle();
    write_reg(REG_THRESHOLD, 32'h0);
    write_reg(REG_THRESHOLD, 32'h0100_0000);
    write_reg(REG_COOLDOWN, 32'hFFFF_0000);
    write_reg(REG_AUTO_FIRE, 32'h0);
    write_reg(REG_COOLDOWN, 32'h1);
    write_reg(REG_THRESHOLD, 32'h1);
    send(CMD_ENABLE, '0);
    send(CMD_ARM, '0);
    send(CMD_ARMED_SAMPLE, 24'd2);
    send(CMD_TICK, '0);
    send(CMD_TICK, '0);
    send(CMD_PASS, '0);
    send(CMD_ARMED_SAMPLE, 24'd5);
    send(CMD_TICK, '0);
    send(CMD_ARMED_SAMPLE, '1);

    run_phase(250, THR_W'($urandom_range(500, 3000)), 1'b1,
              CD_W'($urandom_range(1, 4)), 1'b0);
    run_phase(200, 24'd1, 1'b0, 16'd1, 1'b0);
    run_phase(150, '1, 1'b1, '1, 1'b0);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_phase(250, THR_W'($urandom_range(100, 50000)), 1'b1, 16'd3, 1'b0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_phase(250, THR_W'($urandom_range(100, 50000)), 1'($urandom_range(1)), 16'd2, 1'b1);
    run_phase(300, THR_W'($urandom_range(1, 24'hFFFFFF)), 1'b1,
              CD_W'($urandom_range(1, 16)), 1'b0);

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
